[rtl/core/rdq_pkg.sv]
package rdq_pkg;

   localparam int DEPTH   = 64;
   localparam int WORD_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = ADDR_W + 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      KIND_CLEAR   = 3'd0,
      KIND_LOAD    = 3'd1,
      KIND_REVERSE = 3'd2,
      KIND_DELETE  = 3'd3,
      KIND_DRAIN   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_ERROR = 2'd1,
      OP_EMPTY = 2'd2,
      OP_DRAIN = 2'd3
   } op_type;

   // work passed from front to back; addr is the write slot or the first read slot
   typedef struct packed {
      op_type   op;
      addr_type addr;
      cnt_type  count;
      logic     rev;
      word_type word;
   } cmd_type;

   function automatic addr_type wrap_pos(sum_type s);
      sum_type r;
      r = (s >= sum_type'(DEPTH)) ? s - sum_type'(DEPTH) : s;
      return r[ADDR_W-1:0];
   endfunction

endpackage

[rtl/core/rdq_queue.sv]
module rdq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rdq_pkg::cmd_type push_data,
   output logic             full,
   output logic             pop_valid,
   output rdq_pkg::cmd_type pop_data,
   input  logic             pop
);

   rdq_pkg::cmd_type entries_ff [rdq_pkg::QDEPTH];
   logic [rdq_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rdq_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rdq_pkg::QCNT_W-1:0] fill_ff, fill_in;
   logic do_pop;

   assign full      = (fill_ff == rdq_pkg::QCNT_W'(rdq_pkg::QDEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rdq_pkg::QPTR_W'(rdq_pkg::QDEPTH - 1))
                     ? '0 : wr_ptr_ff + rdq_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rdq_pkg::QPTR_W'(rdq_pkg::QDEPTH - 1))
                     ? '0 : rd_ptr_ff + rdq_pkg::QPTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   fill_in = fill_ff + rdq_pkg::QCNT_W'(1);
         2'b01:   fill_in = fill_ff - rdq_pkg::QCNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/rdq_front.sv]
module rdq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [2:0]       kind,
   input  logic [31:0]      word,
   output logic             push,
   output rdq_pkg::cmd_type push_data
);

   rdq_pkg::addr_type head_ff, head_in;
   rdq_pkg::cnt_type  count_ff, count_in;
   logic              rev_ff, rev_in;
   logic              failed_ff, failed_in;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      failed_in = failed_ff;
      push      = 1'b0;
      push_data = '{op: rdq_pkg::OP_WRITE, addr: '0, count: '0, rev: 1'b0,
                    word: rdq_pkg::word_type'(word)};
      if (accept) begin
         case (rdq_pkg::kind_type'(kind))
            rdq_pkg::KIND_CLEAR: begin
               head_in   = '0;
               count_in  = '0;
               rev_in    = 1'b0;
               failed_in = 1'b0;
            end
            rdq_pkg::KIND_LOAD: begin
               // drop the load when the store is full
               if (count_ff != rdq_pkg::cnt_type'(rdq_pkg::DEPTH)) begin
                  push           = 1'b1;
                  push_data.op   = rdq_pkg::OP_WRITE;
                  push_data.addr = rdq_pkg::wrap_pos(rdq_pkg::sum_type'(head_ff)
                                   + rdq_pkg::sum_type'(count_ff));
                  count_in       = count_ff + rdq_pkg::cnt_type'(1);
               end
            end
            rdq_pkg::KIND_REVERSE: begin
               if (!failed_ff) begin
                  rev_in = !rev_ff;
               end
            end
            rdq_pkg::KIND_DELETE: begin
               if (!failed_ff) begin
                  if (count_ff == '0) begin
                     failed_in    = 1'b1;
                     push         = 1'b1;
                     push_data.op = rdq_pkg::OP_ERROR;
                  end else begin
                     if (!rev_ff) begin
                        head_in = rdq_pkg::wrap_pos(rdq_pkg::sum_type'(head_ff)
                                  + rdq_pkg::sum_type'(1));
                     end
                     count_in = count_ff - rdq_pkg::cnt_type'(1);
                  end
               end
            end
            rdq_pkg::KIND_DRAIN: begin
               if (!failed_ff) begin
                  push = 1'b1;
                  if (count_ff == '0) begin
                     push_data.op = rdq_pkg::OP_EMPTY;
                  end else begin
                     push_data.op    = rdq_pkg::OP_DRAIN;
                     push_data.count = count_ff;
                     push_data.rev   = rev_ff;
                     // reversed drain starts at the physical back
                     push_data.addr  = rev_ff
                        ? rdq_pkg::wrap_pos(rdq_pkg::sum_type'(head_ff)
                          + rdq_pkg::sum_type'(count_ff) - rdq_pkg::sum_type'(1))
                        : head_ff;
                     count_in = '0;
                     head_in  = '0;
                  end
               end
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         rev_ff    <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         rev_ff    <= rev_in;
         failed_ff <= failed_in;
      end
   end

endmodule

[rtl/core/rdq_back.sv]
module rdq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rdq_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_value,
   output logic             rsp_last,
   output logic             rsp_error,
   output logic             rsp_empty_list
);

   rdq_pkg::word_type store_ff [rdq_pkg::DEPTH];

   rdq_pkg::cnt_type  remain_ff, remain_in;
   rdq_pkg::addr_type addr_ff, addr_in;
   logic              rev_ff, rev_in;

   logic              rd_valid_ff, rd_valid_in;
   rdq_pkg::word_type rd_word_ff;
   logic              rd_last_ff, rd_error_ff, rd_empty_ff, rd_zero_ff;

   logic              out_valid_ff, out_valid_in;
   rdq_pkg::word_type out_value_ff;
   logic              out_last_ff, out_error_ff, out_empty_ff;

   logic busy, move, stage_free, issue, pop_write, pop_single, pop_drain;

   assign busy       = (remain_ff != '0);
   assign move       = rd_valid_ff && (!out_valid_ff || !rsp_stall);
   assign stage_free = !rd_valid_ff || move;
   assign issue      = busy && stage_free;
   assign cmd_pop    = !busy && cmd_valid && stage_free;
   assign pop_write  = cmd_pop && (cmd.op == rdq_pkg::OP_WRITE);
   assign pop_drain  = cmd_pop && (cmd.op == rdq_pkg::OP_DRAIN);
   assign pop_single = cmd_pop && ((cmd.op == rdq_pkg::OP_ERROR)
                                   || (cmd.op == rdq_pkg::OP_EMPTY));

   always_comb begin
      remain_in = remain_ff;
      addr_in   = addr_ff;
      rev_in    = rev_ff;
      if (issue) begin
         remain_in = remain_ff - rdq_pkg::cnt_type'(1);
         if (rev_ff) begin
            addr_in = (addr_ff == '0) ? rdq_pkg::addr_type'(rdq_pkg::DEPTH - 1)
                                      : addr_ff - rdq_pkg::addr_type'(1);
         end else begin
            addr_in = rdq_pkg::wrap_pos(rdq_pkg::sum_type'(addr_ff)
                                        + rdq_pkg::sum_type'(1));
         end
      end else if (pop_drain) begin
         remain_in = cmd.count;
         addr_in   = cmd.addr;
         rev_in    = cmd.rev;
      end
   end

   assign rd_valid_in  = issue || pop_single || (rd_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rev_ff  <= rev_in;
   end

   always_ff @(posedge clock) begin
      if (pop_write) begin
         store_ff[cmd.addr] <= cmd.word;
      end
      if (issue) begin
         rd_word_ff <= store_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_last_ff  <= (remain_ff == rdq_pkg::cnt_type'(1));
         rd_error_ff <= 1'b0;
         rd_empty_ff <= 1'b0;
         rd_zero_ff  <= 1'b0;
      end else if (pop_single) begin
         rd_last_ff  <= 1'b1;
         rd_error_ff <= (cmd.op == rdq_pkg::OP_ERROR);
         rd_empty_ff <= (cmd.op == rdq_pkg::OP_EMPTY);
         rd_zero_ff  <= 1'b1;
      end
   end

   // advance the read stage into the output register
   always_ff @(posedge clock) begin
      if (move) begin
         out_value_ff <= rd_zero_ff ? '0 : rd_word_ff;
         out_last_ff  <= rd_last_ff;
         out_error_ff <= rd_error_ff;
         out_empty_ff <= rd_empty_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = 32'(out_value_ff);
   assign rsp_last       = out_last_ff;
   assign rsp_error      = out_error_ff;
   assign rsp_empty_list = out_empty_ff;

endmodule

[rtl/core/reversible_deque_engine.sv]
// Bounded deque of 32-bit words with a read-direction flag.
// Request channel (req_valid, req_stall, req_kind, req_word): clear, load,
// reverse, delete or drain. A request is taken on an edge with req_valid high
// and req_stall low. The front updates head, count, direction and the error
// flag in the cycle it takes the request, so one request per cycle is taken
// while the four-entry command queue to the back has room; req_stall rises
// only when that queue is full.
// Response channel (rsp_valid, rsp_stall, rsp_value, rsp_last, rsp_error,
// rsp_empty_list): a drain of N elements gives N responses, one per cycle
// while the receiver takes them, set by the single read port of the store.
// A failed delete or a drain of an empty list gives one response.
// When the back is idle a single response passes the command queue, the read
// stage and output register; a drain first loads the back's address and count.
// While rsp_stall is high the output register holds its response, the
// read stage behind it fills, and then the back and the queue hold too.
// Reset (synchronous) empties the list, clears direction, error flag, queue
// and pipeline; the store itself is not cleared and needs no clearing pass.
module reversible_deque_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   output logic        rsp_error,
   output logic        rsp_empty_list
);

   logic             q_full, push, q_valid, q_pop, accept;
   rdq_pkg::cmd_type push_data, q_data;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   rdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .word      (req_word),
      .push      (push),
      .push_data (push_data)
   );

   rdq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .pop       (q_pop)
   );

   rdq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd            (q_data),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .rsp_empty_list (rsp_empty_list)
   );

endmodule

[rtl/core/rdq_checker.sv]
module rdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic        rsp_last,
   input logic        rsp_error,
   input logic        rsp_empty_list
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && !rsp_empty_list && (rsp_value == 32'd0))
      else $error("malformed error response");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_list |-> rsp_last && !rsp_error && (rsp_value == 32'd0))
      else $error("malformed empty response");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_hold_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_value) && $stable(rsp_last))
      else $error("response changed while stalled");

endmodule

bind reversible_deque_engine rdq_checker u_rdq_checker (.*);

[tb/reversible_deque_engine_tb.sv]
module reversible_deque_engine_tb;

   localparam int IDLE_LIMIT  = 3000;
   localparam int SETTLE_WAIT = 40;
   localparam int HOLD_OFF    = 600;
   localparam int ITEM_TARGET = 110;

   localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
   localparam logic [2:0] KIND_SPARE_MID = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

   typedef struct packed {
      rdq_pkg::word_type value;
      logic              last;
      logic              error;
      logic              empty_list;
   } rsp_rec_type;

   class deque_scoreboard;
      rdq_pkg::word_type store [rdq_pkg::DEPTH];
      int                head;
      int                count;
      bit                reversed;
      bit                failed;
      rsp_rec_type       expected_rsps [$];
      int                failures;

      function new();
         head     = 0;
         count    = 0;
         reversed = 0;
         failed   = 0;
         failures = 0;
      endfunction

      function int ring_index(int base, int off);
         int p;
         p = base + off;
         if (p >= rdq_pkg::DEPTH) p -= rdq_pkg::DEPTH;
         return p;
      endfunction

      function void add_expectation(rdq_pkg::word_type value, logic last, logic error,
                                    logic empty_list);
         rsp_rec_type r;
         r.value      = value;
         r.last       = last;
         r.error      = error;
         r.empty_list = empty_list;
         expected_rsps.insert(expected_rsps.size(), r);
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      // advance the deque model by one accepted request
      function void note_request(logic [2:0] kind, rdq_pkg::word_type word);
         int i;
         int off;
         case (kind)
            rdq_pkg::KIND_CLEAR: begin
               head     = 0;
               count    = 0;
               reversed = 0;
               failed   = 0;
            end
            rdq_pkg::KIND_LOAD: begin
               if (count < rdq_pkg::DEPTH) begin
                  store[ring_index(head, count)] = word;
                  count++;
               end
            end
            rdq_pkg::KIND_REVERSE: begin
               if (!failed) reversed = !reversed;
            end
            rdq_pkg::KIND_DELETE: begin
               if (!failed) begin
                  if (count == 0) begin
                     failed = 1;
                     add_expectation('0, 1'b1, 1'b1, 1'b0);
                  end else begin
                     // front is the physical back when reversed
                     if (!reversed) head = ring_index(head, 1);
                     count--;
                  end
               end
            end
            rdq_pkg::KIND_DRAIN: begin
               if (!failed) begin
                  if (count == 0) begin
                     add_expectation('0, 1'b1, 1'b0, 1'b1);
                  end else begin
                     for (i = 0; i < count; i++) begin
                        off = reversed ? count - 1 - i : i;
                        add_expectation(store[ring_index(head, off)], i == count - 1,
                                        1'b0, 1'b0);
                     end
                     count = 0;
                     head  = 0;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_response(rdq_pkg::word_type value, logic last, logic error,
                                   logic empty_list);
         rsp_rec_type want;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with nothing expected, expected none, actual %h/%b/%b/%b",
                     $time, value, last, error, empty_list);
            failures++;
         end else begin
            want = expected_rsps[0];
            expected_rsps.delete(0);
            compare_field("value", want.value, value);
            compare_field("last", want.last, last);
            compare_field("error", want.error, error);
            compare_field("empty_list", want.empty_list, empty_list);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [31:0] req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value;
   logic        rsp_last;
   logic        rsp_error;
   logic        rsp_empty_list;

   deque_scoreboard sb;
   int              sent_total;
   int              idle_cycles;

   reversible_deque_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .rsp_empty_list (rsp_empty_list)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_kind, req_word);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_value, rsp_last, rsp_error, rsp_empty_list);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic rdq_pkg::word_type pick_word();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // offer one request and hold it until taken
   task automatic send_request(logic [2:0] kind, rdq_pkg::word_type word);
      int gap;
      gap = (((sent_total / 16) % 3) == 1) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_word  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_total++;
   endtask

   task automatic send_noise();
      send_request(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), $urandom);
   endtask

   // fill to capacity, overflow, delete a few and refill across the wrap point
   task automatic fill_sequence();
      int i;
      int k;
      send_request(rdq_pkg::KIND_CLEAR, $urandom);
      for (i = 0; i <= rdq_pkg::DEPTH; i++) send_request(rdq_pkg::KIND_LOAD, pick_word());
      k = $urandom_range(1, 8);
      for (i = 0; i < k; i++) send_request(rdq_pkg::KIND_DELETE, $urandom);
      for (i = 0; i <= k; i++) send_request(rdq_pkg::KIND_LOAD, pick_word());
      if ($urandom_range(0, 1)) send_request(rdq_pkg::KIND_REVERSE, $urandom);
      send_request(rdq_pkg::KIND_DRAIN, $urandom);
   endtask

   // underflow the list, poke it while failed, then recover
   task automatic broken_sequence();
      int i;
      int len;
      int n;
      send_request(rdq_pkg::KIND_CLEAR, $urandom);
      len = $urandom_range(0, 2);
      for (i = 0; i < len; i++) send_request(rdq_pkg::KIND_LOAD, pick_word());
      for (i = 0; i <= len; i++) send_request(rdq_pkg::KIND_DELETE, $urandom);
      n = $urandom_range(2, 4);
      for (i = 0; i < n; i++)
         send_request(3'($urandom_range(rdq_pkg::KIND_LOAD, rdq_pkg::KIND_DRAIN)),
                      pick_word());
      send_request(rdq_pkg::KIND_CLEAR, $urandom);
   endtask

   task automatic list_sequence();
      int i;
      int n;
      int len;
      int r;
      len = 0;
      if ($urandom_range(0, 3) == 0) begin
         send_request(rdq_pkg::KIND_CLEAR, $urandom);
      end
      n = $urandom_range(0, 10);
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 2) begin
            send_noise();
         end else if (r < 5) begin
            send_request(rdq_pkg::KIND_REVERSE, $urandom);
         end else if (r < 8 && len > 0) begin
            send_request(rdq_pkg::KIND_DELETE, $urandom);
            len--;
         end else begin
            send_request(rdq_pkg::KIND_LOAD, pick_word());
            len++;
         end
      end
      send_request(rdq_pkg::KIND_DRAIN, $urandom);
   endtask

   initial begin
      int taken;
      int hold;
      bit pressed;
      taken     = 0;
      pressed   = 0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // hold off while the reversed drain is still in flight
         if (!pressed && taken >= 2) begin
            pressed = 1;
            hold    = HOLD_OFF;
         end else if (((taken / 16) % 3) == 2) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 13);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      int seq_no;
      sb          = new();
      sent_total  = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = rdq_pkg::KIND_CLEAR;
      req_word    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty drain, underflow, then reverse, delete and drain ignored while failed
      send_request(rdq_pkg::KIND_CLEAR, '0);
      send_request(rdq_pkg::KIND_DRAIN, '0);
      send_request(rdq_pkg::KIND_DELETE, '0);
      send_request(rdq_pkg::KIND_REVERSE, '0);
      send_request(rdq_pkg::KIND_DELETE, '0);
      send_request(rdq_pkg::KIND_DRAIN, '0);
      send_request(rdq_pkg::KIND_LOAD, 32'hAAAA_5555);
      send_request(rdq_pkg::KIND_CLEAR, '1);
      // reversed drain, then direction kept on an empty list
      send_request(rdq_pkg::KIND_LOAD, 32'h0000_0000);
      send_request(rdq_pkg::KIND_LOAD, 32'hFFFF_FFFF);
      send_request(rdq_pkg::KIND_LOAD, 32'h1234_5678);
      send_request(rdq_pkg::KIND_REVERSE, '0);
      send_request(rdq_pkg::KIND_DRAIN, '0);
      send_request(rdq_pkg::KIND_DRAIN, '0);
      send_request(rdq_pkg::KIND_LOAD, 32'h0000_0001);
      send_request(rdq_pkg::KIND_LOAD, 32'h0000_0002);
      send_request(rdq_pkg::KIND_LOAD, 32'h0000_0003);
      send_request(rdq_pkg::KIND_DELETE, '0);
      send_request(rdq_pkg::KIND_REVERSE, '0);
      send_request(rdq_pkg::KIND_DELETE, '0);
      send_request(rdq_pkg::KIND_DRAIN, '0);
      send_request(KIND_SPARE_LO, '1);
      send_request(KIND_SPARE_MID, 32'h5555_AAAA);
      send_request(KIND_SPARE_HI, '1);
      send_request(rdq_pkg::KIND_REVERSE, '0);
      send_request(rdq_pkg::KIND_CLEAR, '0);
      send_request(rdq_pkg::KIND_LOAD, 32'h8000_0001);
      send_request(rdq_pkg::KIND_DRAIN, '0);

      seq_no = 0;
      while (sent_total < ITEM_TARGET) begin
         seq_no++;
         if (seq_no == 1) begin
            fill_sequence();
         end else if ($urandom_range(0, 9) == 0) begin
            broken_sequence();
         end else begin
            list_sequence();
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
